>>> rtl/plec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plec_pkg
// shared types, widths and codes of the positional list engine
// ----------------------------------------------------------------------------
package plec_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int OPC_W  = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 16;
    localparam int ST_W   = 2;
    localparam int FPOS_W = 7;
    localparam int LEN_W  = 7;

    typedef enum logic [OPC_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_FIND   = 2'd2,
        OP_DELETE = 2'd3
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_MISS   = 2'd3
    } status_t;

    // what every cell of the chain does on a command
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_FIND = 2'd3
    } cell_op_t;

    // command broadcast along the chain
    typedef struct packed {
        cell_op_t                  op;
        logic [POS_W-1:0]          idx;
        logic [POS_W-1:0]          fill;
        logic signed [VAL_W-1:0]   value;
    } plec_cmd_t;

    typedef struct packed {
        logic [OPC_W-1:0]          opcode;
        logic signed [VAL_W-1:0]   value;
        logic [POS_W-1:0]          position;
    } plec_req_t;

    typedef struct packed {
        logic [ST_W-1:0]           status;
        logic [FPOS_W-1:0]         found_position;
        logic [LEN_W-1:0]          length;
    } plec_rsp_t;

endpackage
`default_nettype wire

>>> rtl/plec_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plec_stream_if
// valid/ready channel carrying one request or response
// ----------------------------------------------------------------------------
interface plec_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/plec_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plec_cell
// one list slot: shifts with its neighbors, loads, and compares for a find
// ----------------------------------------------------------------------------
module plec_cell
    import plec_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic                    clk,
    input  wire plec_cmd_t               cmd,
    input  wire logic signed [VAL_W-1:0] left_data,
    input  wire logic signed [VAL_W-1:0] right_data,
    output logic signed [VAL_W-1:0]      data,
    output logic                         hit
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;
    logic                    hit_reg;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_INS:
            begin
                if (MY_POS > cmd.idx)
                begin
                    data_next = left_data;
                end
                else if (MY_POS == cmd.idx)
                begin
                    data_next = cmd.value;
                end
            end
            CELL_DEL:
            begin
                if (MY_POS >= cmd.idx)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (cmd.op == CELL_FIND)
        begin
            // only occupied slots may match
            hit_reg <= (data_reg == cmd.value) && (MY_POS < cmd.fill);
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule
`default_nettype wire

>>> rtl/positional_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_core
// ordered list of signed 32-bit values held in a shifting chain of cells
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells; position p sits in cell p-1.
// Each request carries an opcode (append, insert, find, delete), a value and
// a one-based position, where position zero counts as one. Append, insert
// and delete are decided from the fill count alone: the request is accepted,
// the cells at and beyond the target slot shift toward or away from it at
// that same edge, and the response is in the output register on the next
// cycle. For a find, every cell compares its value in parallel and registers
// a hit bit, then a priority encoder over the hit bits picks the first
// occupied match. No request is taken while a find is in flight.
// The response register lets a new request in while the previous response
// is still waiting, as long as that response is being taken in the same
// cycle. Cell contents have no reset; only slots below the fill count are
// ever looked at. Invalid positions and a full list leave the list as it is
// and are reported in the status field.
// ----------------------------------------------------------------------------
module positional_list_engine_core
    import plec_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    plec_stream_if.sink       req,
    plec_stream_if.source     rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic [ST_W-1:0]       status_reg;
    logic [ST_W-1:0]       status_next;
    logic [FPOS_W-1:0]     found_reg;
    logic [FPOS_W-1:0]     found_next;
    logic [LEN_W-1:0]      length_reg;
    logic [LEN_W-1:0]      length_next;
    logic                  rsp_load;

    plec_req_t  req_data;
    plec_cmd_t  cmd;
    logic       accept;

    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  fill;
    logic              full;
    logic              ins_ok;
    logic              del_ok;
    status_t           op_status;

    logic [CAPACITY-1:0][VAL_W-1:0] cell_data;
    logic [CAPACITY-1:0]            cell_hit;
    logic [CW-1:0]                  first_pos;

    // ------------------------------------------------------------------
    // handshake: idle, and the response slot free or draining now
    // ------------------------------------------------------------------
    assign req_data  = req.data;
    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    // ------------------------------------------------------------------
    // position checks against the fill count
    // ------------------------------------------------------------------
    assign pos_eff = (req_data.position == '0) ? POS_W'(1) : req_data.position;
    assign fill    = POS_W'(count_reg);
    assign full    = (count_reg == CW'(CAPACITY));
    // insert is legal up to one past the tail
    assign ins_ok  = {1'b0, pos_eff} <= ({1'b0, fill} + 17'd1);
    // delete is legal up to the tail; an empty list rejects every position
    assign del_ok  = pos_eff <= fill;

    always_comb
    begin
        cmd.op     = CELL_HOLD;
        cmd.idx    = pos_eff - POS_W'(1);
        cmd.fill   = fill;
        cmd.value  = req_data.value;
        count_next = count_reg;
        op_status  = ST_OK;
        state_next = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_data.opcode)
                        OP_APPEND:
                        begin
                            cmd.idx = fill;
                            if (full)
                            begin
                                op_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.op     = CELL_INS;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            // the position check wins over the full check
                            if (!ins_ok)
                            begin
                                op_status = ST_BADPOS;
                            end
                            else if (full)
                            begin
                                op_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.op     = CELL_INS;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_FIND:
                        begin
                            cmd.op     = CELL_FIND;
                            state_next = S_SEARCH;
                        end
                        OP_DELETE:
                        begin
                            if (!del_ok)
                            begin
                                op_status = ST_BADPOS;
                            end
                            else
                            begin
                                cmd.op     = CELL_DEL;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            op_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // the cell chain; the ends see zero beyond the row
    // ------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_nb;
        logic signed [VAL_W-1:0] right_nb;

        if (g == 0)
        begin : g_first
            assign left_nb = '0;
        end
        else
        begin : g_mid_l
            assign left_nb = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_nb = '0;
        end
        else
        begin : g_mid_r
            assign right_nb = cell_data[g+1];
        end

        plec_cell #(
            .IDX (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_data  (left_nb),
            .right_data (right_nb),
            .data       (cell_data[g]),
            .hit        (cell_hit[g])
        );
    end

    // ------------------------------------------------------------------
    // first registered hit, lowest slot wins
    // ------------------------------------------------------------------
    always_comb
    begin
        first_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (cell_hit[i])
            begin
                first_pos = CW'(i + 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // response register
    // ------------------------------------------------------------------
    always_comb
    begin
        rsp_load    = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        length_next = length_reg;

        if (state_reg == S_SEARCH)
        begin
            rsp_load    = 1'b1;
            status_next = (first_pos != '0) ? ST_OK : ST_MISS;
            found_next  = FPOS_W'(first_pos);
            length_next = LEN_W'(count_reg);
        end
        else if (accept && (req_data.opcode != OP_FIND))
        begin
            rsp_load    = 1'b1;
            status_next = op_status;
            found_next  = '0;
            length_next = LEN_W'(count_next);
        end

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            length_reg <= length_next;
        end
    end

    assign rsp.valid               = rsp_valid_reg;
    assign rsp.data.status         = status_reg;
    assign rsp.data.found_position = found_reg;
    assign rsp.data.length         = length_reg;

endmodule
`default_nettype wire

>>> rtl/plec_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plec_checker
// port-level timing checks for the positional list engine
// ----------------------------------------------------------------------------
module plec_checker
    import plec_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic [OPC_W-1:0]  req_opcode,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [ST_W-1:0]   rsp_status,
    input wire logic [FPOS_W-1:0] rsp_found,
    input wire logic [LEN_W-1:0]  rsp_length
);

    logic req_acc;
    logic is_find;

    assign req_acc = req_valid && req_ready;
    assign is_find = (req_opcode == OP_FIND);

    // a stalled response keeps its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_found) && $stable(rsp_length))
        else $error("response changed while stalled");

    // list updates answer in the next cycle
    a_update_lat: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && !is_find |=> rsp_valid)
        else $error("missing response after update request");

    // a find blocks the next request, then answers after its search state
    a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && is_find |=> !req_ready)
        else $error("request taken during find");

    a_find_lat: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && is_find |-> ##2 rsp_valid)
        else $error("missing response after find");

    // every response traces back to a recent request
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_acc) || $past(req_acc, 2))
        else $error("response without request");

endmodule

bind positional_list_engine_core plec_checker u_plec_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_opcode (req.data.opcode),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.data.status),
    .rsp_found  (rsp.data.found_position),
    .rsp_length (rsp.data.length)
);
`default_nettype wire
